FILE: src/ffha_pkg.sv
package ffha_pkg;

    // Heap geometry
    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 32;
    localparam int GRAN_BYTES   = 16;
    localparam int GRAN_SHIFT   = $clog2(GRAN_BYTES);
    localparam int MIN_BLOCK    = 16;
    localparam int GRANULES     = HEAP_BYTES / GRAN_BYTES;
    localparam int HDR_GRAN     = HEADER_BYTES / GRAN_BYTES;

    // Widths
    localparam int GR_W   = $clog2(GRANULES);
    localparam int LINK_W = GR_W + 1;
    localparam int SIZE_W = $clog2(HEAP_BYTES) + 1;
    localparam int REQ_W  = SIZE_W + 1;
    localparam int FAC_W  = $clog2(HEAP_BYTES) + 1;
    localparam int PTR_W  = 12;
    localparam int WORD_W = 32;

    // End-of-list marker in a header link
    localparam logic [LINK_W-1:0] NIL = LINK_W'(GRANULES);

    typedef enum logic [1:0] {
        CMD_MALLOC  = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_CALLOC  = 2'd2,
        CMD_REALLOC = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_GRANT = 2'd0,
        STS_NONE  = 2'd1,
        STS_OOM   = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd              command;
        logic [WORD_W-1:0] request_bytes;
        logic [WORD_W-1:0] element_count;
        logic [PTR_W-1:0]  pointer;
    } t_alloc_req;

    typedef struct packed {
        t_status          status;
        logic [PTR_W-1:0] address;
        logic [PTR_W-1:0] copy_bytes;
        logic [PTR_W-1:0] clear_bytes;
    } t_alloc_rsp;

endpackage

FILE: src/first_fit_heap_allocator_unit.sv
// First-fit heap allocator over a 4096-byte heap with a header table of one entry per
// 16-byte granule. Each command (malloc, free, calloc, realloc) gives exactly one result
// transfer. Malloc-type commands walk the LIFO free list one header per cycle through the
// single read port of the header table, visiting at most 256 headers; calloc first forms
// its size product, and realloc of a live pointer first reads the old header and, after
// a move, releases the old block. The unit accepts one command at a time; a finished
// result sits in an output register, so the next command is taken while the previous
// result still waits. Header contents are not cleared at reset: freeing or reallocating a
// block that was never handed out gives undefined results.
module first_fit_heap_allocator_unit import ffha_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_alloc_req i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_alloc_rsp o_out_data
);

    localparam int CMP_W = REQ_W + 1;
    localparam int GS_W  = GR_W + 3;
    localparam logic [REQ_W-1:0] REQ_SAT = REQ_W'(1) << (REQ_W - 1);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_WSTART = 13'b0000000000010,
        S_WCHK   = 13'b0000000000100,
        S_FIT    = 13'b0000000001000,
        S_SPLIT  = 13'b0000000010000,
        S_LINK   = 13'b0000000100000,
        S_CLAIM  = 13'b0000001000000,
        S_GROW   = 13'b0000010000000,
        S_ROLD   = 13'b0000100000000,
        S_RCHK   = 13'b0001000000000,
        S_MUL    = 13'b0010000000000,
        S_REL    = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    // What follows a successful block take
    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_CALLOC = 2'd1,
        MODE_MOVE   = 2'd2
    } t_mode;

    // Round a byte count up to whole granules, at least one block. Anything at or above
    // the saturation value can neither fit a header nor grow the heap, so it is clipped.
    function automatic logic [REQ_W-1:0] round_req(input logic [WORD_W-1:0] n);
        logic [REQ_W-1:0] r;
        if (n[WORD_W-1:REQ_W-1] != '0) begin
            r = REQ_SAT;
        end else begin
            r = ({1'b0, n[REQ_W-2:0]} + REQ_W'(GRAN_BYTES - 1)) & ~REQ_W'(GRAN_BYTES - 1);
        end
        if (r < REQ_W'(MIN_BLOCK)) begin
            r = REQ_W'(MIN_BLOCK);
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] user_ptr(input logic [GR_W-1:0] g);
        return PTR_W'({g, {GRAN_SHIFT{1'b0}}}) + PTR_W'(HEADER_BYTES);
    endfunction

    // Header table: three memories sharing one read address
    logic [SIZE_W-1:0] r_hdr_size [GRANULES];
    logic [LINK_W-1:0] r_hdr_next [GRANULES];
    logic              r_hdr_free [GRANULES];
    logic [SIZE_W-1:0] r_rd_size;
    logic [LINK_W-1:0] r_rd_next;
    logic              r_rd_free;

    logic              rd_en;
    logic [GR_W-1:0]   rd_addr;
    logic              size_we, next_we, free_we;
    logic [GR_W-1:0]   size_wa, next_wa, free_wa;
    logic [SIZE_W-1:0] size_wd;
    logic [LINK_W-1:0] next_wd;
    logic              free_wd;

    // Control state
    t_state            r_state, n_state;
    logic [LINK_W-1:0] r_head, n_head;
    logic [SIZE_W-1:0] r_heap_top, n_heap_top;
    logic              r_out_valid, n_out_valid;

    // Per-command working registers
    logic [REQ_W-1:0]  r_req, n_req;
    logic [GR_W-1:0]   r_old, n_old;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    t_mode             r_mode, n_mode;
    logic [PTR_W-1:0]  r_aux, n_aux;
    logic [FAC_W-1:0]  r_fa, n_fa, r_fb, n_fb;
    logic [GR_W-1:0]   r_cur, n_cur;
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [LINK_W-1:0] r_steps, n_steps;
    logic              r_split, n_split;
    logic [GR_W-1:0]   r_g, n_g;
    logic [SIZE_W-1:0] r_gsize, n_gsize;
    logic [LINK_W-1:0] r_link, n_link;
    t_alloc_rsp        r_res, n_res;
    t_alloc_rsp        r_out_data, n_out_data;

    logic              in_xfer;
    logic [PTR_W-1:0]  in_h;
    logic              in_ptr_ok;
    logic [GR_W-1:0]   in_gran;
    logic              fit, big, g_ok;
    logic [GS_W-1:0]   g_sum;
    logic [SIZE_W-1:0] gsize;
    logic [LINK_W-1:0] steps_inc;
    logic              end_walk;
    logic [CMP_W-1:0]  top_sum;
    logic              grow_ok;
    logic [2*FAC_W-1:0] prod;
    logic              take_done;
    logic [GR_W-1:0]   take_g;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A user pointer is valid when it lies past a header on a granule boundary.
    assign in_h      = i_in_data.pointer - PTR_W'(HEADER_BYTES);
    assign in_ptr_ok = (i_in_data.pointer >= PTR_W'(HEADER_BYTES))
                    && (in_h[GRAN_SHIFT-1:0] == '0)
                    && ((in_h >> GRAN_SHIFT) < PTR_W'(GRANULES));
    assign in_gran   = GR_W'(in_h >> GRAN_SHIFT);

    // Shared compare unit of the walk: does the header just read fit the request?
    assign fit = r_rd_free && (REQ_W'(r_rd_size) >= r_req);

    // Split decision: the remainder must hold a header and a minimum block, and the new
    // header must still land inside the table.
    assign big   = CMP_W'(r_rd_size) >= CMP_W'(r_req) + CMP_W'(HEADER_BYTES + MIN_BLOCK);
    assign g_sum = GS_W'(r_cur) + GS_W'(HDR_GRAN) + GS_W'(r_req >> GRAN_SHIFT);
    assign g_ok  = g_sum < GS_W'(GRANULES);
    assign gsize = r_rd_size - SIZE_W'(r_req) - SIZE_W'(HEADER_BYTES);

    assign steps_inc = r_steps + LINK_W'(1);
    assign end_walk  = r_rd_next[GR_W] || (steps_inc == LINK_W'(GRANULES));

    assign top_sum = CMP_W'(r_heap_top) + CMP_W'(HEADER_BYTES) + CMP_W'(r_req);
    assign grow_ok = top_sum <= CMP_W'(HEAP_BYTES);

    assign prod = r_fa * r_fb;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_heap_top  = r_heap_top;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        n_req       = r_req;
        n_old       = r_old;
        n_ptr       = r_ptr;
        n_mode      = r_mode;
        n_aux       = r_aux;
        n_fa        = r_fa;
        n_fb        = r_fb;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_split     = r_split;
        n_g         = r_g;
        n_gsize     = r_gsize;
        n_link      = r_link;
        n_res       = r_res;
        rd_en       = 1'b0;
        rd_addr     = '0;
        size_we     = 1'b0;
        size_wa     = '0;
        size_wd     = '0;
        next_we     = 1'b0;
        next_wa     = '0;
        next_wd     = '0;
        free_we     = 1'b0;
        free_wa     = '0;
        free_wd     = 1'b0;
        take_done   = 1'b0;
        take_g      = '0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res.status      = STS_NONE;
                    n_res.address     = '0;
                    n_res.copy_bytes  = '0;
                    n_res.clear_bytes = '0;
                    n_mode            = MODE_PLAIN;
                    n_ptr             = i_in_data.pointer;
                    n_old             = in_gran;
                    n_req             = round_req(i_in_data.request_bytes);
                    n_state           = S_DONE;
                    case (i_in_data.command)
                        CMD_MALLOC: begin
                            if (i_in_data.request_bytes != '0) begin
                                n_state = S_WSTART;
                            end
                        end
                        CMD_FREE: begin
                            if (in_ptr_ok) begin
                                n_state = S_REL;
                            end
                        end
                        CMD_CALLOC: begin
                            if (i_in_data.element_count != '0
                                    && i_in_data.request_bytes != '0) begin
                                if (i_in_data.element_count > WORD_W'(HEAP_BYTES)
                                        || i_in_data.request_bytes > WORD_W'(HEAP_BYTES)) begin
                                    n_res.status = STS_OOM;
                                end else begin
                                    n_fa    = FAC_W'(i_in_data.element_count);
                                    n_fb    = FAC_W'(i_in_data.request_bytes);
                                    n_mode  = MODE_CALLOC;
                                    n_state = S_MUL;
                                end
                            end
                        end
                        CMD_REALLOC: begin
                            if (i_in_data.pointer == '0) begin
                                if (i_in_data.request_bytes != '0) begin
                                    n_state = S_WSTART;
                                end
                            end else if (!in_ptr_ok) begin
                                n_res.status = STS_OOM;
                            end else if (i_in_data.request_bytes == '0) begin
                                n_state = S_REL;
                            end else begin
                                n_state = S_ROLD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_MUL: begin
                if (prod > (2*FAC_W)'(HEAP_BYTES)) begin
                    n_res.status = STS_OOM;
                    n_state      = S_DONE;
                end else begin
                    n_req   = round_req(WORD_W'(prod));
                    n_aux   = prod[PTR_W-1:0];
                    n_state = S_WSTART;
                end
            end

            S_ROLD: begin
                rd_en   = 1'b1;
                rd_addr = r_old;
                n_state = S_RCHK;
            end

            S_RCHK: begin
                if (REQ_W'(r_rd_size) >= r_req) begin
                    n_res.status  = STS_GRANT;
                    n_res.address = r_ptr;
                    n_state       = S_DONE;
                end else begin
                    n_aux   = r_rd_size[PTR_W-1:0];
                    n_mode  = MODE_MOVE;
                    n_state = S_WSTART;
                end
            end

            S_WSTART: begin
                n_prev  = NIL;
                n_steps = '0;
                n_cur   = r_head[GR_W-1:0];
                if (r_head[GR_W]) begin
                    n_state = S_GROW;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head[GR_W-1:0];
                    n_state = S_WCHK;
                end
            end

            S_WCHK: begin
                n_steps = steps_inc;
                if (fit) begin
                    n_state = S_FIT;
                end else begin
                    n_prev = {1'b0, r_cur};
                    n_cur  = r_rd_next[GR_W-1:0];
                    if (end_walk) begin
                        n_state = S_GROW;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_rd_next[GR_W-1:0];
                    end
                end
            end

            S_FIT: begin
                n_split = big && g_ok;
                n_g     = g_sum[GR_W-1:0];
                n_gsize = gsize;
                n_link  = (big && g_ok) ? {1'b0, g_sum[GR_W-1:0]} : r_rd_next;
                n_state = (big && g_ok) ? S_SPLIT : S_LINK;
            end

            S_SPLIT: begin
                // New free header behind the granted part inherits the old link.
                size_we = 1'b1;
                size_wa = r_g;
                size_wd = r_gsize;
                next_we = 1'b1;
                next_wa = r_g;
                next_wd = r_rd_next;
                free_we = 1'b1;
                free_wa = r_g;
                free_wd = 1'b1;
                n_state = S_LINK;
            end

            S_LINK: begin
                if (r_split) begin
                    size_we = 1'b1;
                    size_wa = r_cur;
                    size_wd = SIZE_W'(r_req);
                end
                if (r_prev[GR_W]) begin
                    n_head = r_link;
                end else begin
                    next_we = 1'b1;
                    next_wa = r_prev[GR_W-1:0];
                    next_wd = r_link;
                end
                n_state = S_CLAIM;
            end

            S_CLAIM: begin
                free_we   = 1'b1;
                free_wa   = r_cur;
                free_wd   = 1'b0;
                next_we   = 1'b1;
                next_wa   = r_cur;
                next_wd   = NIL;
                take_done = 1'b1;
                take_g    = r_cur;
            end

            S_GROW: begin
                if (grow_ok) begin
                    size_we    = 1'b1;
                    size_wa    = r_heap_top[GR_W+GRAN_SHIFT-1:GRAN_SHIFT];
                    size_wd    = SIZE_W'(r_req);
                    next_we    = 1'b1;
                    next_wa    = r_heap_top[GR_W+GRAN_SHIFT-1:GRAN_SHIFT];
                    next_wd    = NIL;
                    free_we    = 1'b1;
                    free_wa    = r_heap_top[GR_W+GRAN_SHIFT-1:GRAN_SHIFT];
                    free_wd    = 1'b0;
                    n_heap_top = SIZE_W'(top_sum);
                    take_done  = 1'b1;
                    take_g     = r_heap_top[GR_W+GRAN_SHIFT-1:GRAN_SHIFT];
                end else begin
                    n_res.status = STS_OOM;
                    n_state      = S_DONE;
                end
            end

            S_REL: begin
                free_we = 1'b1;
                free_wa = r_old;
                free_wd = 1'b1;
                next_we = 1'b1;
                next_wa = r_old;
                next_wd = r_head;
                n_head  = {1'b0, r_old};
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A block has been taken: report it, then release the old block of a moving realloc.
        if (take_done) begin
            n_res.status  = STS_GRANT;
            n_res.address = user_ptr(take_g);
            if (r_mode == MODE_CALLOC) begin
                n_res.clear_bytes = r_aux;
            end
            if (r_mode == MODE_MOVE) begin
                n_res.copy_bytes = r_aux;
                n_state          = S_REL;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (size_we) begin
            r_hdr_size[size_wa] <= size_wd;
        end
        if (rd_en) begin
            r_rd_size <= r_hdr_size[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_hdr_next[next_wa] <= next_wd;
        end
        if (rd_en) begin
            r_rd_next <= r_hdr_next[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_we) begin
            r_hdr_free[free_wa] <= free_wd;
        end
        if (rd_en) begin
            r_rd_free <= r_hdr_free[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NIL;
            r_heap_top  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_heap_top  <= n_heap_top;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_req      <= n_req;
        r_old      <= n_old;
        r_ptr      <= n_ptr;
        r_mode     <= n_mode;
        r_aux      <= n_aux;
        r_fa       <= n_fa;
        r_fb       <= n_fb;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_steps    <= n_steps;
        r_split    <= n_split;
        r_g        <= n_g;
        r_gsize    <= n_gsize;
        r_link     <= n_link;
        r_res      <= n_res;
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != S_IDLE))
        else $error("command transfer did not start processing");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready))
            |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result was not loaded into the output register");

    a_no_grant_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != STS_GRANT)
            |-> (o_out_data.address == '0 && o_out_data.copy_bytes == '0
                 && o_out_data.clear_bytes == '0))
        else $error("result without a pointer carries nonzero fields");

    a_heap_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_heap_top <= SIZE_W'(HEAP_BYTES)) && (r_heap_top[GRAN_SHIFT-1:0] == '0))
        else $error("heap top out of range or off a granule boundary");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WCHK) |-> (r_steps < LINK_W'(GRANULES)))
        else $error("free-list walk exceeded one visit per granule");

endmodule

FILE: dv/heap_alloc_checker.sv
module heap_alloc_checker import ffha_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_alloc_req i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_alloc_rsp i_out_data,
    output int         o_fail_count,
    output int         o_outstanding
);

    // Shadow copy of the header table and the allocator registers.
    logic [SIZE_W-1:0] blk_size [GRANULES];
    logic [LINK_W-1:0] blk_link [GRANULES];
    logic              blk_free [GRANULES];
    logic [LINK_W-1:0] free_head = NIL;
    logic [SIZE_W-1:0] brk_top   = '0;

    t_alloc_rsp expected_rsp_q [$];
    int         mismatches = 0;

    task automatic clear_shadow();
        foreach (blk_size[i]) begin
            blk_size[i] = '0;
            blk_link[i] = '0;
            blk_free[i] = 1'b0;
        end
        free_head = NIL;
        brk_top   = '0;
        expected_rsp_q.delete();
    endtask

    function automatic logic [63:0] round_up(input logic [63:0] n);
        logic [63:0] r;
        r = (n + 64'(GRAN_BYTES - 1)) & ~64'(GRAN_BYTES - 1);
        return (r < 64'(MIN_BLOCK)) ? 64'(MIN_BLOCK) : r;
    endfunction

    function automatic logic [PTR_W-1:0] user_addr(input logic [LINK_W-1:0] g);
        return PTR_W'(g * GRAN_BYTES + HEADER_BYTES);
    endfunction

    function automatic logic [LINK_W-1:0] header_granule(input logic [PTR_W-1:0] p);
        int h;
        if (p < HEADER_BYTES) return NIL;
        h = int'(p) - HEADER_BYTES;
        if ((h % GRAN_BYTES) != 0 || (h / GRAN_BYTES) >= GRANULES) return NIL;
        return LINK_W'(h / GRAN_BYTES);
    endfunction

    function automatic void push_free(input logic [LINK_W-1:0] g);
        blk_free[g[GR_W-1:0]] = 1'b1;
        blk_link[g[GR_W-1:0]] = free_head;
        free_head = g;
    endfunction

    // First-fit walk of the free list, falling back to growing the heap.
    // Returns the granted header granule or NIL.
    function automatic logic [LINK_W-1:0] carve_block(input logic [63:0] need);
        logic [LINK_W-1:0] prev, cur, g;
        logic [63:0]       off;
        int                steps;
        prev  = NIL;
        cur   = free_head;
        steps = 0;
        while (cur < GRANULES && steps < GRANULES) begin
            steps++;
            if (blk_free[cur[GR_W-1:0]] && blk_size[cur[GR_W-1:0]] >= need) begin
                if (blk_size[cur[GR_W-1:0]] >= need + HEADER_BYTES + MIN_BLOCK) begin
                    off = 64'(cur) * GRAN_BYTES + HEADER_BYTES + need;
                    if (off / GRAN_BYTES < GRANULES) begin
                        g = LINK_W'(off / GRAN_BYTES);
                        blk_size[g[GR_W-1:0]] =
                            SIZE_W'(blk_size[cur[GR_W-1:0]] - need - HEADER_BYTES);
                        blk_link[g[GR_W-1:0]] = blk_link[cur[GR_W-1:0]];
                        blk_free[g[GR_W-1:0]] = 1'b1;
                        blk_size[cur[GR_W-1:0]] = SIZE_W'(need);
                        blk_link[cur[GR_W-1:0]] = g;
                    end
                end
                if (prev < GRANULES) begin
                    blk_link[prev[GR_W-1:0]] = blk_link[cur[GR_W-1:0]];
                end else begin
                    free_head = blk_link[cur[GR_W-1:0]];
                end
                blk_free[cur[GR_W-1:0]] = 1'b0;
                blk_link[cur[GR_W-1:0]] = NIL;
                return cur;
            end
            prev = cur;
            cur  = blk_link[cur[GR_W-1:0]];
        end
        if (64'(brk_top) + HEADER_BYTES + need > 64'(HEAP_BYTES)) return NIL;
        g = LINK_W'(brk_top / GRAN_BYTES);
        blk_size[g[GR_W-1:0]] = SIZE_W'(need);
        blk_link[g[GR_W-1:0]] = NIL;
        blk_free[g[GR_W-1:0]] = 1'b0;
        brk_top = SIZE_W'(64'(brk_top) + HEADER_BYTES + need);
        return g;
    endfunction

    function automatic t_alloc_rsp predict_alloc(input t_alloc_req rq);
        t_alloc_rsp        rs;
        logic [63:0]       total;
        logic [63:0]       need;
        logic [LINK_W-1:0] g;
        logic [LINK_W-1:0] old;
        logic [SIZE_W-1:0] old_size;
        rs.status      = STS_NONE;
        rs.address     = '0;
        rs.copy_bytes  = '0;
        rs.clear_bytes = '0;
        case (rq.command)
            CMD_MALLOC: begin
                if (rq.request_bytes != 0) begin
                    g = carve_block(round_up(64'(rq.request_bytes)));
                    if (g < GRANULES) begin
                        rs.status  = STS_GRANT;
                        rs.address = user_addr(g);
                    end else begin
                        rs.status = STS_OOM;
                    end
                end
            end
            CMD_FREE: begin
                if (rq.pointer != 0) begin
                    old = header_granule(rq.pointer);
                    if (old < GRANULES) push_free(old);
                end
            end
            CMD_CALLOC: begin
                if (rq.element_count != 0 && rq.request_bytes != 0) begin
                    total = 64'(rq.element_count) * 64'(rq.request_bytes);
                    if (total > 64'(HEAP_BYTES)) begin
                        rs.status = STS_OOM;
                    end else begin
                        g = carve_block(round_up(total));
                        if (g < GRANULES) begin
                            rs.status      = STS_GRANT;
                            rs.address     = user_addr(g);
                            rs.clear_bytes = PTR_W'(total);
                        end else begin
                            rs.status = STS_OOM;
                        end
                    end
                end
            end
            CMD_REALLOC: begin
                if (rq.pointer == 0) begin
                    if (rq.request_bytes != 0) begin
                        g = carve_block(round_up(64'(rq.request_bytes)));
                        if (g < GRANULES) begin
                            rs.status  = STS_GRANT;
                            rs.address = user_addr(g);
                        end else begin
                            rs.status = STS_OOM;
                        end
                    end
                end else begin
                    old = header_granule(rq.pointer);
                    if (old >= GRANULES) begin
                        rs.status = STS_OOM;
                    end else if (rq.request_bytes == 0) begin
                        push_free(old);
                    end else begin
                        need     = round_up(64'(rq.request_bytes));
                        old_size = blk_size[old[GR_W-1:0]];
                        if (old_size >= need) begin
                            rs.status  = STS_GRANT;
                            rs.address = rq.pointer;
                        end else begin
                            // The old block is released only once the move has succeeded.
                            g = carve_block(need);
                            if (g < GRANULES) begin
                                rs.status     = STS_GRANT;
                                rs.address    = user_addr(g);
                                rs.copy_bytes = PTR_W'(old_size);
                                push_free(old);
                            end else begin
                                rs.status = STS_OOM;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return rs;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    initial clear_shadow();

    always @(posedge i_clk) begin
        t_alloc_rsp want;
        if (!i_rst_n) begin
            clear_shadow();
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_rsp_q.push_back(predict_alloc(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("result transfer with no command outstanding: status %0d address %0d",
                           i_out_data.status, i_out_data.address);
                    mismatches++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    check_field("status", want.status, i_out_data.status);
                    check_field("address", want.address, i_out_data.address);
                    check_field("copy_bytes", want.copy_bytes, i_out_data.copy_bytes);
                    check_field("clear_bytes", want.clear_bytes, i_out_data.clear_bytes);
                end
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= expected_rsp_q.size();
    end

endmodule

FILE: dv/first_fit_heap_allocator_unit_tb.sv
// Stimulus and verdict for the first-fit heap allocator. The checker instance beside the
// block watches both channels, predicts every result and counts mismatches; this module
// only drives commands, keeps track of which pointers it may legally hand back, and
// decides pass or fail at the end of the run.
module first_fit_heap_allocator_unit_tb;
    import ffha_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int PHASE_ITEMS  = 526;
    // A malloc-type command may walk up to one header per granule, so let the block
    // settle for longer than one full walk once the last result has arrived.
    localparam int DRAIN_CYCLES = 320;
    // Worst case is about 1600 commands each walking the whole table while both sides
    // stall; the ceiling is several times that.
    localparam int CYCLE_LIMIT  = 2_500_000;

    // Bookkeeping for a command that has been transferred but not yet answered.
    typedef struct {
        t_cmd             cmd;
        logic [PTR_W-1:0] ptr;
        bit               restore;
    } t_issued;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_alloc_req in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_alloc_rsp out_data;

    int fail_count;
    int outstanding;

    int          tx_idle     = 0;
    int          rx_idle     = 0;
    bit          lockstep    = 1'b0;
    int unsigned cycle_count = 0;

    t_issued          issued_q [$];
    // Pointers currently owned by the stimulus, and every pointer ever granted. Only a
    // granted pointer has a header that the block has written, so only those (besides
    // plainly malformed ones) are ever freed or reallocated.
    logic [PTR_W-1:0] live_ptrs [$];
    logic [PTR_W-1:0] granted_ptrs [$];
    bit               granted_map [GRANULES];
    logic [PTR_W-1:0] last_grant = '0;

    always #CLK_HALF clk = ~clk;

    first_fit_heap_allocator_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    heap_alloc_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // The receiver stalls at random; the percentage changes with the phase of the run.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle);
    end

    // A hung block must not keep the run going for ever.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("first_fit_heap_allocator_unit verification failed");
            $finish;
        end
    end

    // Follow the results so that later commands can refer to granted blocks. A realloc
    // that failed leaves its old block with the owner, so that pointer goes back into
    // the live set.
    always @(posedge clk) begin : follow_results
        t_issued     note;
        logic [11:0] hdr;
        if (rst_n && out_valid && out_ready && issued_q.size() != 0) begin
            note = issued_q.pop_front();
            hdr  = out_data.address - 12'(HEADER_BYTES);
            if (out_data.status == STS_GRANT && note.cmd != CMD_FREE
                    && out_data.address >= HEADER_BYTES && hdr[GRAN_SHIFT-1:0] == '0) begin
                live_ptrs.push_back(out_data.address);
                last_grant = out_data.address;
                if (!granted_map[hdr[GR_W+GRAN_SHIFT-1:GRAN_SHIFT]]) begin
                    granted_map[hdr[GR_W+GRAN_SHIFT-1:GRAN_SHIFT]] = 1'b1;
                    granted_ptrs.push_back(out_data.address);
                end
            end else if (out_data.status == STS_OOM && note.restore) begin
                live_ptrs.push_back(note.ptr);
            end
        end
    end

    // One command transfer. Called at a falling edge and returns at a falling edge, so the
    // valid line is assigned once per time step even when commands follow back to back.
    task automatic drive_command(input t_alloc_req rq, input t_issued note);
        while ($urandom_range(0, 99) < tx_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rq;
        do @(posedge clk); while (!in_ready);
        issued_q.push_back(note);
        @(negedge clk);
    endtask

    // Build a command, take its pointer out of the live set if it gives the block back,
    // and send it. In lockstep mode the task also waits for the answer, which the
    // directed part needs in order to reuse the granted pointer.
    task automatic issue(input t_cmd cmd, input logic [31:0] size, input logic [31:0] count,
                         input logic [PTR_W-1:0] ptr);
        t_alloc_req rq;
        t_issued    note;
        int         idx;
        note.cmd     = cmd;
        note.ptr     = ptr;
        note.restore = 1'b0;
        idx          = -1;
        if (cmd == CMD_FREE || cmd == CMD_REALLOC) begin
            foreach (live_ptrs[k]) begin
                if (idx < 0 && ptr != 0 && live_ptrs[k] == ptr) idx = k;
            end
            if (idx >= 0) begin
                live_ptrs.delete(idx);
                note.restore = (cmd == CMD_REALLOC) && (size != 0);
            end
        end
        rq.command       = cmd;
        rq.request_bytes = size;
        rq.element_count = count;
        rq.pointer       = ptr;
        drive_command(rq, note);
        // While waiting for the answer the command must not be offered a second time.
        if (lockstep) begin
            in_valid <= 1'b0;
            while (issued_q.size() != 0) @(negedge clk);
        end
    endtask

    // Mostly small requests so that the heap turns over, with a few large and a few
    // absurd ones.
    function automatic logic [31:0] rand_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)  return '0;
        if (pick < 70) return $urandom_range(1, 64);
        if (pick < 90) return $urandom_range(65, 512);
        if (pick < 97) return $urandom_range(513, HEAP_BYTES);
        return $urandom;
    endfunction

    // A pointer that is either below the header or off the granule grid.
    function automatic logic [PTR_W-1:0] bad_pointer();
        logic [PTR_W-1:0] p;
        if ($urandom_range(0, 1) == 0) return PTR_W'($urandom_range(1, HEADER_BYTES - 1));
        p      = PTR_W'($urandom);
        p[3:0] = 4'($urandom_range(1, 15));
        return p;
    endfunction

    task automatic random_command();
        int               sel;
        logic [PTR_W-1:0] p;
        sel = $urandom_range(0, 99);
        // Keep the number of live blocks bounded so that the free list stays busy.
        if (live_ptrs.size() > 48 && sel < 60) sel = 50;
        if (sel >= 35 && sel < 65 && live_ptrs.size() == 0) sel = 0;
        if (sel < 35) begin
            issue(CMD_MALLOC, rand_size(), $urandom, PTR_W'($urandom));
        end else if (sel < 65) begin
            issue(CMD_FREE, $urandom, $urandom,
                  live_ptrs[$urandom_range(0, live_ptrs.size() - 1)]);
        end else if (sel < 77) begin
            sel = $urandom_range(0, 9);
            if (sel < 8) begin
                issue(CMD_CALLOC, $urandom_range(1, 64), $urandom_range(1, 16), '0);
            end else if (sel == 8) begin
                issue(CMD_CALLOC, $urandom_range(0, 1) ? 32'd0 : $urandom,
                      32'd0, PTR_W'($urandom));
            end else begin
                issue(CMD_CALLOC, $urandom, $urandom, PTR_W'($urandom));
            end
        end else if (sel < 92) begin
            if (live_ptrs.size() == 0 || $urandom_range(0, 9) == 0) p = '0;
            else p = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
            issue(CMD_REALLOC, rand_size(), $urandom, p);
        end else begin
            // Malformed traffic: bad pointers, a free of any block ever granted (which may be
            // a second free and then tangles the free list) and huge requests.
            case ($urandom_range(0, 3))
                0: issue(CMD_FREE, $urandom, $urandom, bad_pointer());
                1: issue(CMD_REALLOC, rand_size(), $urandom, bad_pointer());
                2: begin
                    if (granted_ptrs.size() == 0) p = bad_pointer();
                    else p = granted_ptrs[$urandom_range(0, granted_ptrs.size() - 1)];
                    issue(CMD_FREE, $urandom, $urandom, p);
                end
                default: issue(CMD_MALLOC, $urandom | 32'h0001_0000, $urandom, '0);
            endcase
        end
    endtask

    initial begin
        logic [PTR_W-1:0] p_small;
        logic [PTR_W-1:0] p_moved;
        logic [PTR_W-1:0] p_grown;
        foreach (granted_map[i]) granted_map[i] = 1'b0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, one command at a time.
        lockstep = 1'b1;
        issue(CMD_MALLOC, 32'd0, 32'd0, '0);
        issue(CMD_MALLOC, 32'd1, 32'd0, '0);
        p_small = last_grant;
        issue(CMD_MALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        // Calloc with either factor zero, with an overflowing product, one that fits,
        // and one whose product is legal but cannot be placed.
        issue(CMD_CALLOC, 32'd0, 32'hFFFF_FFFF, '0);
        issue(CMD_CALLOC, 32'hFFFF_FFFF, 32'd0, '0);
        issue(CMD_CALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        issue(CMD_CALLOC, 32'd4, 32'd25, '0);
        issue(CMD_CALLOC, 32'(HEAP_BYTES), 32'd1, '0);
        // Free of null, of a pointer inside the header, and of one off the grid.
        issue(CMD_FREE, 32'd0, 32'd0, '0);
        issue(CMD_FREE, 32'd0, 32'd0, 12'd16);
        issue(CMD_FREE, 32'd0, 32'd0, 12'hFFF);
        // Realloc of null behaves as malloc; a malformed pointer is refused.
        issue(CMD_REALLOC, 32'd0, 32'd0, '0);
        issue(CMD_REALLOC, 32'd40, 32'd0, '0);
        p_grown = last_grant;
        issue(CMD_REALLOC, 32'd16, 32'd0, 12'd7);
        // Same block when it is big enough, a move with a copy when it is not, a failed
        // move that leaves the old block alone, and realloc to zero which frees it.
        issue(CMD_REALLOC, 32'd48, 32'd0, p_grown);
        issue(CMD_REALLOC, 32'd200, 32'd0, p_grown);
        p_moved = last_grant;
        issue(CMD_REALLOC, 32'hFFFF_FFFF, 32'd0, p_moved);
        issue(CMD_REALLOC, 32'd0, 32'd0, p_moved);
        // The freed 208-byte block now heads the list and is split for a small request.
        issue(CMD_MALLOC, 32'd16, 32'd0, '0);
        // Freeing the same block twice leaves a loop in the free list.
        issue(CMD_FREE, 32'd0, 32'd0, p_small);
        issue(CMD_FREE, 32'd0, 32'd0, p_small);
        issue(CMD_MALLOC, 32'd16, 32'd0, '0);
        // Grow the heap until it is full.
        issue(CMD_MALLOC, 32'd3000, 32'd0, '0);
        issue(CMD_MALLOC, 32'd3000, 32'd0, '0);
        lockstep = 1'b0;

        // Random part in three phases of back-pressure: a slow receiver, then a slow
        // sender, then neither side idling at all.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle = (phase == 0) ? 13 : (phase == 1) ? 53 : 0;
            rx_idle = (phase == 0) ? 53 : (phase == 1) ? 13 : 0;
            repeat (PHASE_ITEMS) random_command();
        end
        in_valid <= 1'b0;

        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0) begin
            $display("first_fit_heap_allocator_unit verification clean");
        end else begin
            $display("first_fit_heap_allocator_unit verification failed");
        end
        $finish;
    end

endmodule
